### src/ckre_pkg.sv
`timescale 1ns / 1ps

package ckre_pkg;

  // Geometry and batch limits
  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int BATCH_RECTS = 2000;

  localparam int CHAN_W = 8;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = COL_W + 1;
  localparam int HDIM_W = ROW_W + 1;
  localparam int CNT_W  = $clog2(BATCH_RECTS + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 13;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_RED      = 3'd0,
    REG_KEY_GREEN    = 3'd1,
    REG_KEY_BLUE     = 3'd2,
    REG_TOL_RED      = 3'd3,
    REG_TOL_GREEN    = 3'd4,
    REG_TOL_BLUE     = 3'd5,
    REG_FRAME_WIDTH  = 3'd6,
    REG_FRAME_HEIGHT = 3'd7
  } reg_idx_t;

  // Result kinds
  localparam logic KIND_SPAN  = 1'b0;
  localparam logic KIND_BATCH = 1'b1;

  // Decoded configuration seen by the run tracker
  typedef struct packed {
    logic [CHAN_W-1:0] lo_red;
    logic [CHAN_W-1:0] lo_green;
    logic [CHAN_W-1:0] lo_blue;
    logic [CHAN_W-1:0] hi_red;
    logic [CHAN_W-1:0] hi_green;
    logic [CHAN_W-1:0] hi_blue;
    logic [DIM_W-1:0]  width;
    logic [HDIM_W-1:0] height;
  } ckre_cfg_t;

  // One result item
  typedef struct packed {
    logic              kind;
    logic [COL_W-1:0]  span_start;
    logic [DIM_W-1:0]  span_end;
    logic [ROW_W-1:0]  span_row;
    logic [DIM_W-1:0]  box_left;
    logic [HDIM_W-1:0] box_top;
    logic [DIM_W-1:0]  box_right;
    logic [HDIM_W-1:0] box_bottom;
    logic [CNT_W-1:0]  batch_count;
    logic              frame_done;
  } ckre_res_t;

  // Results produced by one pixel, packed towards slot zero
  typedef struct packed {
    logic [1:0]      count;
    ckre_res_t [2:0] res;
  } ckre_push_t;

  // Upper bound of a colour band, saturating at full scale
  function automatic logic [CHAN_W-1:0] band_top(input logic [CHAN_W-1:0] key,
                                                 input logic [CHAN_W-1:0] tol);
    logic [CHAN_W:0] sum;
    sum = {1'b0, key} + {1'b0, tol};
    return sum[CHAN_W] ? {CHAN_W{1'b1}} : sum[CHAN_W-1:0];
  endfunction

endpackage

### src/ckre_pixel_if.sv
`timescale 1ns / 1ps

interface ckre_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [ckre_pkg::CHAN_W-1:0] red;
  logic [ckre_pkg::CHAN_W-1:0] green;
  logic [ckre_pkg::CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### src/ckre_result_if.sv
`timescale 1ns / 1ps

interface ckre_result_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [ckre_pkg::COL_W-1:0]  span_start;
  logic [ckre_pkg::DIM_W-1:0]  span_end;
  logic [ckre_pkg::ROW_W-1:0]  span_row;
  logic [ckre_pkg::DIM_W-1:0]  box_left;
  logic [ckre_pkg::HDIM_W-1:0] box_top;
  logic [ckre_pkg::DIM_W-1:0]  box_right;
  logic [ckre_pkg::HDIM_W-1:0] box_bottom;
  logic [ckre_pkg::CNT_W-1:0]  batch_count;
  logic                        frame_done;

  modport source (output valid, output kind, output span_start, output span_end,
                  output span_row, output box_left, output box_top, output box_right,
                  output box_bottom, output batch_count, output frame_done,
                  input ready);
  modport sink   (input valid, input kind, input span_start, input span_end,
                  input span_row, input box_left, input box_top, input box_right,
                  input box_bottom, input batch_count, input frame_done,
                  output ready);
endinterface

### src/ckre_cfg_if.sv
`timescale 1ns / 1ps

interface ckre_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ckre_pkg::CFG_IDX_W-1:0]  index;
  logic [ckre_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/ckre_cfg_regs.sv
`timescale 1ns / 1ps

module ckre_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  ckre_cfg_if.sink            cfg,
  output ckre_pkg::ckre_cfg_t settings
);

  logic [ckre_pkg::CHAN_W-1:0]     key_red, key_green, key_blue;
  logic [ckre_pkg::CHAN_W-1:0]     tol_red, tol_green, tol_blue;
  logic [ckre_pkg::CFG_DATA_W-1:0] frame_width, frame_height;

  // Writes are always taken
  assign cfg.ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      key_red      <= '0;
      key_green    <= '0;
      key_blue     <= '0;
      tol_red      <= '0;
      tol_green    <= '0;
      tol_blue     <= '0;
      frame_width  <= ckre_pkg::CFG_DATA_W'(640);
      frame_height <= ckre_pkg::CFG_DATA_W'(480);
    end else if (cfg.valid) begin
      unique case (ckre_pkg::reg_idx_t'(cfg.index))
        ckre_pkg::REG_KEY_RED:      key_red      <= cfg.data[ckre_pkg::CHAN_W-1:0];
        ckre_pkg::REG_KEY_GREEN:    key_green    <= cfg.data[ckre_pkg::CHAN_W-1:0];
        ckre_pkg::REG_KEY_BLUE:     key_blue     <= cfg.data[ckre_pkg::CHAN_W-1:0];
        ckre_pkg::REG_TOL_RED:      tol_red      <= cfg.data[ckre_pkg::CHAN_W-1:0];
        ckre_pkg::REG_TOL_GREEN:    tol_green    <= cfg.data[ckre_pkg::CHAN_W-1:0];
        ckre_pkg::REG_TOL_BLUE:     tol_blue     <= cfg.data[ckre_pkg::CHAN_W-1:0];
        ckre_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg.data;
        ckre_pkg::REG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Band limits and clamped geometry: zero counts as one, oversize saturates
  always_comb begin
    settings.lo_red   = key_red;
    settings.lo_green = key_green;
    settings.lo_blue  = key_blue;
    settings.hi_red   = ckre_pkg::band_top(key_red, tol_red);
    settings.hi_green = ckre_pkg::band_top(key_green, tol_green);
    settings.hi_blue  = ckre_pkg::band_top(key_blue, tol_blue);

    if (frame_width == '0) begin
      settings.width = ckre_pkg::DIM_W'(1);
    end else if ({1'b0, frame_width} > 14'(ckre_pkg::MAX_WIDTH)) begin
      settings.width = ckre_pkg::DIM_W'(ckre_pkg::MAX_WIDTH);
    end else begin
      settings.width = ckre_pkg::DIM_W'(frame_width);
    end

    if (frame_height == '0) begin
      settings.height = ckre_pkg::HDIM_W'(1);
    end else if ({1'b0, frame_height} > 14'(ckre_pkg::MAX_HEIGHT)) begin
      settings.height = ckre_pkg::HDIM_W'(ckre_pkg::MAX_HEIGHT);
    end else begin
      settings.height = ckre_pkg::HDIM_W'(frame_height);
    end
  end

endmodule

### src/ckre_run_tracker.sv
`timescale 1ns / 1ps

module ckre_run_tracker (
  input  logic                 clk,
  input  logic                 rst,
  ckre_pixel_if.sink           pixels,
  input  ckre_pkg::ckre_cfg_t  settings,
  input  logic                 room,
  output ckre_pkg::ckre_push_t push
);

  // Input register
  logic                        pix_valid;
  logic [ckre_pkg::CHAN_W-1:0] pix_red, pix_green, pix_blue;

  // Scan and batch state
  logic [ckre_pkg::COL_W-1:0]  column, column_next;
  logic [ckre_pkg::ROW_W-1:0]  row, row_next;
  logic                        in_span, in_span_next;
  logic [ckre_pkg::COL_W-1:0]  span_begin, span_begin_next;
  logic [ckre_pkg::CNT_W-1:0]  spans_in_batch, spans_in_batch_next;
  logic [ckre_pkg::DIM_W-1:0]  bound_left, bound_left_next;
  logic [ckre_pkg::HDIM_W-1:0] bound_top, bound_top_next;
  logic [ckre_pkg::DIM_W-1:0]  bound_right, bound_right_next;
  logic [ckre_pkg::HDIM_W-1:0] bound_bottom, bound_bottom_next;

  logic process;

  assign process      = pix_valid && room;
  assign pixels.ready = !pix_valid || process;

  // Pixel holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (pixels.valid && pixels.ready) begin
      pix_valid <= 1'b1;
    end else if (process) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixels.valid && pixels.ready) begin
      pix_red   <= pixels.red;
      pix_green <= pixels.green;
      pix_blue  <= pixels.blue;
    end
  end

  // Classify the pixel, close runs and batches, advance the raster position
  always_comb begin
    logic                        clear;
    logic                        last_col;
    logic                        last_row;
    logic                        span_hit;
    logic                        batch_full;
    logic                        frame_end;
    logic [ckre_pkg::DIM_W-1:0]  col_plus;
    logic [ckre_pkg::HDIM_W-1:0] row_plus;
    logic [ckre_pkg::COL_W-1:0]  x0;
    logic [ckre_pkg::DIM_W-1:0]  x1;
    logic [ckre_pkg::CNT_W-1:0]  cnt_plus;
    ckre_pkg::ckre_res_t         span_res;
    ckre_pkg::ckre_res_t         full_res;
    ckre_pkg::ckre_res_t         frame_res;

    clear = (pix_red >= settings.lo_red) && (pix_red <= settings.hi_red)
         && (pix_green >= settings.lo_green) && (pix_green <= settings.hi_green)
         && (pix_blue >= settings.lo_blue) && (pix_blue <= settings.hi_blue);
    col_plus = {1'b0, column} + ckre_pkg::DIM_W'(1);
    row_plus = {1'b0, row} + ckre_pkg::HDIM_W'(1);
    last_col = col_plus >= settings.width;
    last_row = row_plus >= settings.height;

    // At most one span per pixel: a run closed by a clear pixel, or one
    // cut off at the end of the row
    span_hit = (clear && in_span) || (last_col && !clear);
    x0       = (!clear && !in_span) ? column : span_begin;
    x1       = clear ? {1'b0, column} : col_plus;

    span_res             = '0;
    span_res.kind        = ckre_pkg::KIND_SPAN;
    span_res.span_start  = x0;
    span_res.span_end    = x1;
    span_res.span_row    = row;

    // Batch state after the span is counted
    bound_left_next     = bound_left;
    bound_top_next      = bound_top;
    bound_right_next    = bound_right;
    bound_bottom_next   = bound_bottom;
    spans_in_batch_next = spans_in_batch;
    cnt_plus            = spans_in_batch + ckre_pkg::CNT_W'(1);
    if (span_hit) begin
      if ({1'b0, x0} < bound_left) bound_left_next = {1'b0, x0};
      if ({1'b0, row} < bound_top) bound_top_next = {1'b0, row};
      if (x1 > bound_right) bound_right_next = x1;
      if (row_plus > bound_bottom) bound_bottom_next = row_plus;
      spans_in_batch_next = cnt_plus;
    end
    batch_full = span_hit && (cnt_plus >= ckre_pkg::CNT_W'(ckre_pkg::BATCH_RECTS));

    full_res             = '0;
    full_res.kind        = ckre_pkg::KIND_BATCH;
    full_res.box_left    = bound_left_next;
    full_res.box_top     = bound_top_next;
    full_res.box_right   = bound_right_next;
    full_res.box_bottom  = bound_bottom_next;
    full_res.batch_count = spans_in_batch_next;

    if (batch_full) begin
      spans_in_batch_next = '0;
      bound_left_next     = ckre_pkg::DIM_W'(ckre_pkg::MAX_WIDTH);
      bound_top_next      = ckre_pkg::HDIM_W'(ckre_pkg::MAX_HEIGHT);
      bound_right_next    = '0;
      bound_bottom_next   = '0;
    end

    // End of frame closes whatever batch is left, empty or not
    frame_end             = last_col && last_row;
    frame_res             = '0;
    frame_res.kind        = ckre_pkg::KIND_BATCH;
    frame_res.box_left    = bound_left_next;
    frame_res.box_top     = bound_top_next;
    frame_res.box_right   = bound_right_next;
    frame_res.box_bottom  = bound_bottom_next;
    frame_res.batch_count = spans_in_batch_next;
    frame_res.frame_done  = 1'b1;

    if (frame_end) begin
      spans_in_batch_next = '0;
      bound_left_next     = ckre_pkg::DIM_W'(ckre_pkg::MAX_WIDTH);
      bound_top_next      = ckre_pkg::HDIM_W'(ckre_pkg::MAX_HEIGHT);
      bound_right_next    = '0;
      bound_bottom_next   = '0;
    end

    // Run state
    in_span_next    = !clear && !last_col;
    span_begin_next = (!clear && !in_span) ? column : span_begin;

    // Raster position
    if (last_col) begin
      column_next = '0;
      row_next    = last_row ? '0 : row_plus[ckre_pkg::ROW_W-1:0];
    end else begin
      column_next = col_plus[ckre_pkg::COL_W-1:0];
      row_next    = row;
    end

    // Pack the results towards slot zero; a full batch always follows a span
    push.res[0] = span_hit ? span_res : frame_res;
    push.res[1] = batch_full ? full_res : frame_res;
    push.res[2] = frame_res;
    push.count  = process ? (2'({1'b0, span_hit} + {1'b0, batch_full})
                             + 2'({1'b0, frame_end})) : 2'd0;
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      column         <= '0;
      row            <= '0;
      in_span        <= 1'b0;
      span_begin     <= '0;
      spans_in_batch <= '0;
      bound_left     <= ckre_pkg::DIM_W'(ckre_pkg::MAX_WIDTH);
      bound_top      <= ckre_pkg::HDIM_W'(ckre_pkg::MAX_HEIGHT);
      bound_right    <= '0;
      bound_bottom   <= '0;
    end else if (process) begin
      column         <= column_next;
      row            <= row_next;
      in_span        <= in_span_next;
      span_begin     <= span_begin_next;
      spans_in_batch <= spans_in_batch_next;
      bound_left     <= bound_left_next;
      bound_top      <= bound_top_next;
      bound_right    <= bound_right_next;
      bound_bottom   <= bound_bottom_next;
    end
  end

endmodule

### src/ckre_result_fifo.sv
`timescale 1ns / 1ps

module ckre_result_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  ckre_pkg::ckre_push_t push,
  output logic                 room,
  ckre_result_if.source        results
);

  localparam int DEPTH = 8;
  localparam int PTR_W = $clog2(DEPTH);

  ckre_pkg::ckre_res_t entries [DEPTH];
  logic [PTR_W-1:0]    head, tail;
  logic [PTR_W:0]      fill;
  logic                pop;
  ckre_pkg::ckre_res_t front;

  // Room for the largest group one pixel can produce
  assign room = fill <= (PTR_W+1)'(DEPTH - 3);
  assign pop  = results.valid && results.ready;

  // Queue storage: up to three beats written per cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push.count) begin
        entries[tail + PTR_W'(i)] <= push.res[i];
      end
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      tail <= tail + PTR_W'(push.count);
      if (pop) head <= head + PTR_W'(1);
      fill <= fill + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
    end
  end

  // Head of the queue drives the result channel
  assign front               = entries[head];
  assign results.valid       = fill != '0;
  assign results.kind        = front.kind;
  assign results.span_start  = front.span_start;
  assign results.span_end    = front.span_end;
  assign results.span_row    = front.span_row;
  assign results.box_left    = front.box_left;
  assign results.box_top     = front.box_top;
  assign results.box_right   = front.box_right;
  assign results.box_bottom  = front.box_bottom;
  assign results.batch_count = front.batch_count;
  assign results.frame_done  = front.frame_done;

endmodule

### src/color_key_run_extractor.sv
`timescale 1ns / 1ps

// Channel   Role    Beat contents
// pixels    sink    red, green, blue of one pixel in raster order
// results   source  span or batch-closed record with bounding box
// cfg       sink    register index and write data
//
// One pixel is taken every cycle while the result queue has room; each pixel
// gives up to three result beats. A pixel is held in the input register, and
// its results go into an eight-entry result queue. Pixels stall only when fewer
// than three queue entries are free, so stalls come from the result side.
// Reset is synchronous; the register file returns to a 640 by 480 frame.

module color_key_run_extractor (
  input  logic          clk,
  input  logic          rst,
  ckre_pixel_if.sink    pixels,
  ckre_result_if.source results,
  ckre_cfg_if.sink      cfg
);

  ckre_pkg::ckre_cfg_t  settings;
  ckre_pkg::ckre_push_t push;
  logic                 room;

  ckre_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .settings (settings)
  );

  ckre_run_tracker u_run_tracker (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pixels),
    .settings (settings),
    .room     (room),
    .push     (push)
  );

  ckre_result_fifo u_result_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .results (results)
  );

endmodule
